@@ hdl/lisr_pkg.sv @@
`timescale 1ns / 1ps

package lisr_pkg;

    // Frame store geometry
    localparam int MAX_FRAMES = 1024;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);

    // Sample and frame formats
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int FRAC_W   = 16;

    // Rates, step and position
    localparam int RATE_W = 19;
    localparam int STEP_W = RATE_W + FRAC_W;
    localparam int POS_W  = 48;
    localparam logic [RATE_W-1:0] SRC_RATE_RESET = RATE_W'(48000);
    localparam logic [RATE_W-1:0] DST_RATE_RESET = RATE_W'(48000);

    // Bit-serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = STEP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Product of a 17-bit difference and a zero-extended 16-bit unsigned fraction
    localparam int PROD_W = 2 * (SAMPLE_W + 1);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_SRC_RATE = 1'b0,
        REG_DST_RATE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [RATE_W-1:0] src_rate;
        logic [RATE_W-1:0] dst_rate;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] f0;
        logic [FRAME_W-1:0] f1;
        logic [FRAC_W-1:0]  frac;
    } lerp_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_OUT
    } state_t;

endpackage

@@ hdl/lisr_cfg.sv @@
`timescale 1ns / 1ps

module lisr_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lisr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lisr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lisr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output lisr_pkg::cfg_t                  cfg_o
);

    logic [lisr_pkg::RATE_W-1:0] src_rate_reg;
    logic [lisr_pkg::RATE_W-1:0] dst_rate_reg;
    lisr_pkg::reg_idx_t          reg_idx;
    logic                        wr_en;

    // Registers sit on 32-bit words
    assign reg_idx = lisr_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Write registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_rate_reg <= lisr_pkg::SRC_RATE_RESET;
            dst_rate_reg <= lisr_pkg::DST_RATE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                lisr_pkg::REG_SRC_RATE: src_rate_reg <= pwdata[lisr_pkg::RATE_W-1:0];
                lisr_pkg::REG_DST_RATE: dst_rate_reg <= pwdata[lisr_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            lisr_pkg::REG_SRC_RATE: prdata = lisr_pkg::APB_DATA_W'(src_rate_reg);
            lisr_pkg::REG_DST_RATE: prdata = lisr_pkg::APB_DATA_W'(dst_rate_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg_o.src_rate = src_rate_reg;
    assign cfg_o.dst_rate = dst_rate_reg;

endmodule

@@ hdl/lisr_div.sv @@
`timescale 1ns / 1ps

module lisr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start_i,
    input  logic [lisr_pkg::RATE_W-1:0] src_i,
    input  logic [lisr_pkg::RATE_W-1:0] den_i,
    output logic                        busy_o,
    output logic [lisr_pkg::STEP_W-1:0] quot_o
);

    logic [lisr_pkg::STEP_W-1:0]    num_reg;
    logic [lisr_pkg::RATE_W-1:0]    rem_reg;
    logic [lisr_pkg::RATE_W-1:0]    den_reg;
    logic [lisr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [lisr_pkg::RATE_W:0]      rem_shift;
    logic [lisr_pkg::RATE_W:0]      diff;
    logic                           ge;

    // One restoring step: bring down the next dividend bit, try the subtract
    assign rem_shift = {rem_reg, num_reg[lisr_pkg::STEP_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign ge        = !diff[lisr_pkg::RATE_W];

    // Control: step count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start_i) begin
            cnt_reg <= lisr_pkg::DIV_CNT_W'(lisr_pkg::DIV_STEPS);
        end else if (busy_o) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Datapath: quotient bits shift in where dividend bits leave
    always_ff @(posedge aclk) begin
        if (start_i) begin
            num_reg <= {src_i, lisr_pkg::FRAC_W'(0)};
            rem_reg <= '0;
            den_reg <= den_i;
        end else if (busy_o) begin
            num_reg <= {num_reg[lisr_pkg::STEP_W-2:0], ge};
            rem_reg <= ge ? diff[lisr_pkg::RATE_W-1:0] : rem_shift[lisr_pkg::RATE_W-1:0];
        end
    end

    assign busy_o = (cnt_reg != '0);
    assign quot_o = num_reg;

endmodule

@@ hdl/lisr_lerp.sv @@
`timescale 1ns / 1ps

module lisr_lerp (
    input  logic                                 aclk,
    input  logic                                 en_i,
    input  lisr_pkg::lerp_req_t                  req_i,
    output logic signed [lisr_pkg::SAMPLE_W-1:0] out_left_o,
    output logic signed [lisr_pkg::SAMPLE_W-1:0] out_right_o
);

    localparam int SW = lisr_pkg::SAMPLE_W;
    localparam int PW = lisr_pkg::PROD_W;

    logic signed [SW:0]        diff_l;
    logic signed [SW:0]        diff_r;
    logic signed [lisr_pkg::FRAC_W:0] frac_s;
    logic signed [PW-1:0]      prod_l_reg;
    logic signed [PW-1:0]      prod_r_reg;
    logic signed [SW-1:0]      s0_l_reg;
    logic signed [SW-1:0]      s0_r_reg;
    logic [PW-lisr_pkg::FRAC_W-1:0] sum_l;
    logic [PW-lisr_pkg::FRAC_W-1:0] sum_r;

    // Differences between neighbor frames, left in the low half
    assign diff_l = $signed({req_i.f1[SW-1], req_i.f1[SW-1:0]})
                  - $signed({req_i.f0[SW-1], req_i.f0[SW-1:0]});
    assign diff_r = $signed({req_i.f1[2*SW-1], req_i.f1[2*SW-1:SW]})
                  - $signed({req_i.f0[2*SW-1], req_i.f0[2*SW-1:SW]});
    assign frac_s = $signed({1'b0, req_i.frac});

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (en_i) begin
            prod_l_reg <= diff_l * frac_s;
            prod_r_reg <= diff_r * frac_s;
            s0_l_reg   <= $signed(req_i.f0[SW-1:0]);
            s0_r_reg   <= $signed(req_i.f0[2*SW-1:SW]);
        end
    end

    // Arithmetic shift by the fraction width, then add the base sample
    assign sum_l = {{(PW-lisr_pkg::FRAC_W-SW){s0_l_reg[SW-1]}}, s0_l_reg}
                 + prod_l_reg[PW-1:lisr_pkg::FRAC_W];
    assign sum_r = {{(PW-lisr_pkg::FRAC_W-SW){s0_r_reg[SW-1]}}, s0_r_reg}
                 + prod_r_reg[PW-1:lisr_pkg::FRAC_W];

    assign out_left_o  = $signed(sum_l[SW-1:0]);
    assign out_right_o = $signed(sum_r[SW-1:0]);

endmodule

@@ hdl/lisr_ctrl.sv @@
`timescale 1ns / 1ps

module lisr_ctrl (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lisr_pkg::cfg_t                       cfg_i,
    // tdata: in_left, in_right; tuser: mode, first
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lisr_pkg::FRAME_W-1:0]         s_tdata,
    input  logic [1:0]                           s_tuser,
    // tdata: out_left, out_right; tuser: held
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lisr_pkg::FRAME_W-1:0]         m_tdata,
    output logic [0:0]                           m_tuser,
    output logic                                 div_start_o,
    input  logic                                 div_busy_i,
    input  logic [lisr_pkg::STEP_W-1:0]          div_quot_i,
    output logic                                 lerp_en_o,
    output lisr_pkg::lerp_req_t                  lerp_req_o,
    input  logic signed [lisr_pkg::SAMPLE_W-1:0] lerp_left_i,
    input  logic signed [lisr_pkg::SAMPLE_W-1:0] lerp_right_i
);

    localparam int AW = lisr_pkg::ADDR_W;
    localparam int CW = lisr_pkg::COUNT_W;
    localparam int PW = lisr_pkg::POS_W;
    localparam int FW = lisr_pkg::FRAC_W;

    lisr_pkg::state_t state_reg;
    lisr_pkg::state_t state_next;

    logic                        accept;
    logic                        is_load;
    logic                        is_emit;
    logic                        first_bit;
    logic                        wr_en;
    logic                        rd_en;
    logic                        out_load;
    logic                        silent_now;
    logic                        at_end;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_base;
    logic [CW-1:0]               last_idx;
    logic [PW-1:0]               position_reg;
    logic [PW:0]                 pos_sum;
    logic [lisr_pkg::STEP_W-1:0] step_reg;
    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               rd_addr;
    logic [FW-1:0]               frac_reg;
    logic                        held_reg;
    logic                        silent_reg;
    logic [lisr_pkg::FRAME_W-1:0] frame_mem [lisr_pkg::MAX_FRAMES];
    logic [lisr_pkg::FRAME_W-1:0] rd_data_reg;
    logic [lisr_pkg::FRAME_W-1:0] f0_reg;
    logic                        out_valid_reg;
    logic                        out_held_reg;
    logic [lisr_pkg::FRAME_W-1:0] out_data_reg;

    // Decode the incoming item
    assign accept    = s_tvalid && s_tready;
    assign is_load   = accept && !s_tuser[0];
    assign is_emit   = accept && s_tuser[0];
    assign first_bit = s_tuser[1];

    // Load bookkeeping: a batch start rewinds the count
    assign count_base  = first_bit ? '0 : count_reg;
    assign wr_en       = is_load && (count_base < CW'(lisr_pkg::MAX_FRAMES));
    assign div_start_o = is_load && first_bit && (cfg_i.dst_rate != '0);

    // Emit decisions from the current position
    assign last_idx   = count_reg - 1'b1;
    assign silent_now = (count_reg == '0) || (cfg_i.src_rate == '0)
                     || (cfg_i.dst_rate == '0);
    assign at_end     = position_reg[PW-1:FW] >= (PW-FW)'(last_idx);
    assign pos_sum    = {1'b0, position_reg} + (PW+1)'(step_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lisr_pkg::ST_IDLE: begin
                if (is_emit) begin
                    state_next = silent_now ? lisr_pkg::ST_OUT : lisr_pkg::ST_RD0;
                end else if (div_start_o) begin
                    state_next = lisr_pkg::ST_DIV;
                end
            end
            lisr_pkg::ST_DIV: begin
                if (!div_busy_i) begin
                    state_next = lisr_pkg::ST_IDLE;
                end
            end
            lisr_pkg::ST_RD0: state_next = lisr_pkg::ST_RD1;
            lisr_pkg::ST_RD1: state_next = lisr_pkg::ST_MUL;
            lisr_pkg::ST_MUL: state_next = lisr_pkg::ST_OUT;
            lisr_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = lisr_pkg::ST_IDLE;
                end
            end
            default: state_next = lisr_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        lerp_en_o = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            lisr_pkg::ST_IDLE: s_tready = 1'b1;
            lisr_pkg::ST_DIV:  ;
            lisr_pkg::ST_RD0:  rd_en = 1'b1;
            lisr_pkg::ST_RD1: begin
                rd_en = 1'b1;
                if (!held_reg) begin
                    rd_addr = AW'(idx_reg + 1'b1);
                end
            end
            lisr_pkg::ST_MUL:  lerp_en_o = 1'b1;
            lisr_pkg::ST_OUT:  out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lisr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Frame store: single port, writes only on loads, reads only in the read states
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[count_base[AW-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // Batch state: count, position, step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            position_reg <= '0;
            step_reg     <= '0;
        end else begin
            if (is_load) begin
                count_reg <= wr_en ? CW'(count_base + 1'b1) : count_base;
                if (first_bit) begin
                    position_reg <= '0;
                    if (cfg_i.dst_rate == '0) begin
                        step_reg <= '0;
                    end
                end
            end
            if (state_reg == lisr_pkg::ST_DIV && !div_busy_i) begin
                step_reg <= div_quot_i;
            end
            // Advance and saturate the position
            if (is_emit && !silent_now) begin
                position_reg <= pos_sum[PW] ? '1 : pos_sum[PW-1:0];
            end
        end
    end

    // Capture the emit's index and fraction, hold the last frame near the end
    always_ff @(posedge aclk) begin
        if (is_emit) begin
            idx_reg    <= at_end ? last_idx[AW-1:0] : position_reg[FW+AW-1:FW];
            frac_reg   <= at_end ? '0 : position_reg[FW-1:0];
            held_reg   <= at_end || silent_now;
            silent_reg <= silent_now;
        end
        if (state_reg == lisr_pkg::ST_RD1) begin
            f0_reg <= rd_data_reg;
        end
    end

    assign lerp_req_o.f0   = f0_reg;
    assign lerp_req_o.f1   = rd_data_reg;
    assign lerp_req_o.frac = frac_reg;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= silent_reg ? '0 : {lerp_right_i, lerp_left_i};
            out_held_reg <= held_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_held_reg;

    // The frame count never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(lisr_pkg::MAX_FRAMES))
        else $error("frame count beyond store depth");

    // Only entries below the frame count are read
    a_read_written: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (CW'(rd_addr) < count_reg))
        else $error("frame store read past the loaded frames");

    // A silent emit leaves the position alone
    a_silent_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_emit && silent_now) |=> $stable(position_reg))
        else $error("position moved on a silent emit");

    // A held result never interpolates between two frames
    a_held_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lisr_pkg::ST_MUL && held_reg) |-> (frac_reg == '0))
        else $error("held frame with nonzero fraction");

endmodule

@@ hdl/linear_interp_stereo_resampler.sv @@
`timescale 1ns / 1ps

// Stereo 16-bit linear-interpolation resampler. Items with tuser[0]=0 load one
// source frame into a 1024-entry frame store (tuser[1]=1 starts a new batch,
// rewinding the frame count and position and computing the Q19.16 step
// src_rate/dst_rate); items with tuser[0]=1 emit one interpolated output frame,
// with tuser=1 on the result when the last frame was held or silence was sent.
// A batch-start load with a nonzero dst_rate then keeps tready low while the
// bit-serial divider produces the 35-bit step, one quotient bit per cycle. An emit
// takes the two neighbor frames from the single-port frame store in two successive
// reads, then passes one multiply stage and the output register; a silent emit goes
// straight to the output register. Loads are taken while a finished result waits
// on the output. Rates are written over APB at byte addresses 0 (src_rate) and 4
// (dst_rate) while the block is idle, a user rule that the block does not enforce.
module linear_interp_stereo_resampler (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lisr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lisr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lisr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // tdata: in_left [15:0], in_right [31:16]; tuser: mode [0], first [1]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lisr_pkg::FRAME_W-1:0]    s_tdata,
    input  logic [1:0]                      s_tuser,
    // tdata: out_left [15:0], out_right [31:16]; tuser: held [0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lisr_pkg::FRAME_W-1:0]    m_tdata,
    output logic [0:0]                      m_tuser
);

    lisr_pkg::cfg_t                       cfg;
    logic                                 div_start;
    logic                                 div_busy;
    logic [lisr_pkg::STEP_W-1:0]          div_quot;
    logic                                 lerp_en;
    lisr_pkg::lerp_req_t                  lerp_req;
    logic signed [lisr_pkg::SAMPLE_W-1:0] lerp_left;
    logic signed [lisr_pkg::SAMPLE_W-1:0] lerp_right;

    lisr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    lisr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (div_start),
        .src_i   (cfg.src_rate),
        .den_i   (cfg.dst_rate),
        .busy_o  (div_busy),
        .quot_o  (div_quot)
    );

    lisr_lerp u_lerp (
        .aclk        (aclk),
        .en_i        (lerp_en),
        .req_i       (lerp_req),
        .out_left_o  (lerp_left),
        .out_right_o (lerp_right)
    );

    lisr_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .div_start_o  (div_start),
        .div_busy_i   (div_busy),
        .div_quot_i   (div_quot),
        .lerp_en_o    (lerp_en),
        .lerp_req_o   (lerp_req),
        .lerp_left_i  (lerp_left),
        .lerp_right_i (lerp_right)
    );

endmodule

@@ verif/tb_linear_interp_stereo_resampler.sv @@
`timescale 1ns / 1ps

module tb_linear_interp_stereo_resampler;
    import lisr_pkg::*;

    localparam int          RATE_TOP     = 384000;
    localparam int          SETTLE_CYCLES = 50;
    localparam int unsigned CYCLE_LIMIT  = 3000000;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                held;
    } out_frame_t;

    // Predicted resampler: frame store, batch state and expected output frames
    class stereo_lerp_model;
        logic [FRAME_W-1:0]  frames [MAX_FRAMES];
        int unsigned         count;
        logic [POS_W-1:0]    pos;
        logic [STEP_W-1:0]   step;
        logic [RATE_W-1:0]   src;
        logic [RATE_W-1:0]   dst;
        out_frame_t          frames_due[$];
        int unsigned         errors;

        function new();
            count  = 0;
            pos    = '0;
            step   = '0;
            src    = SRC_RATE_RESET;
            dst    = DST_RATE_RESET;
            errors = 0;
        endfunction

        function void set_rate(reg_idx_t idx, logic [RATE_W-1:0] value);
            case (idx)
                REG_SRC_RATE: src = value;
                REG_DST_RATE: dst = value;
            endcase
        endfunction

        // Floor of the weighted difference, added to the first sample
        function logic [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                            logic signed [SAMPLE_W-1:0] b,
                                            logic [FRAC_W-1:0] frac);
            longint diff;
            longint prod;
            diff = longint'(b) - longint'(a);
            prod = diff * longint'({1'b0, frac});
            return SAMPLE_W'(longint'(a) + (prod >>> FRAC_W));
        endfunction

        function void take_item(bit emit, bit first, logic [SAMPLE_W-1:0] left,
                                logic [SAMPLE_W-1:0] right);
            out_frame_t        res;
            logic [POS_W-1:0]  whole;
            logic [FRAC_W-1:0] frac;
            logic [POS_W:0]    sum;
            logic [STEP_W-1:0] num;
            logic [FRAME_W-1:0] f0;
            logic [FRAME_W-1:0] f1;
            int unsigned       idx;
            // Load: restart the batch on first, drop frames into a full store
            if (!emit) begin
                if (first) begin
                    count = 0;
                    pos   = '0;
                    num   = {src, {FRAC_W{1'b0}}};
                    step  = (dst != 0) ? num / STEP_W'(dst) : '0;
                end
                if (count < MAX_FRAMES) begin
                    frames[count] = {right, left};
                    count++;
                end
                return;
            end
            // Silence: nothing loaded or a zero rate
            if (count == 0 || src == 0 || dst == 0) begin
                res.left  = '0;
                res.right = '0;
                res.held  = 1'b1;
                frames_due.push_back(res);
                return;
            end
            whole    = pos >> FRAC_W;
            frac     = pos[FRAC_W-1:0];
            res.held = 1'b0;
            if (whole >= POS_W'(count - 1)) begin
                idx      = count - 1;
                frac     = '0;
                res.held = 1'b1;
            end else begin
                idx = int'(whole);
            end
            f0 = frames[idx];
            f1 = res.held ? f0 : frames[idx + 1];
            res.left  = blend(f0[SAMPLE_W-1:0], f1[SAMPLE_W-1:0], frac);
            res.right = blend(f0[FRAME_W-1:SAMPLE_W], f1[FRAME_W-1:SAMPLE_W], frac);
            frames_due.push_back(res);
            // Advance the position, saturating at the top
            sum = {1'b0, pos} + (POS_W + 1)'(step);
            pos = sum[POS_W] ? '1 : sum[POS_W-1:0];
        endfunction

        function void check_frame(logic [FRAME_W-1:0] data, logic held);
            out_frame_t exp_frame;
            if (frames_due.size() == 0) begin
                $display("%0t: output frame %h held %b with none expected", $time, data, held);
                errors++;
                return;
            end
            exp_frame = frames_due.pop_front();
            if (data[SAMPLE_W-1:0] !== exp_frame.left) begin
                $display("%0t: out_left expected %h actual %h", $time, exp_frame.left,
                         data[SAMPLE_W-1:0]);
                errors++;
            end
            if (data[FRAME_W-1:SAMPLE_W] !== exp_frame.right) begin
                $display("%0t: out_right expected %h actual %h", $time, exp_frame.right,
                         data[FRAME_W-1:SAMPLE_W]);
                errors++;
            end
            if (held !== exp_frame.held) begin
                $display("%0t: held expected %b actual %b", $time, exp_frame.held, held);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // in_left [15:0], in_right [31:16]
    logic [FRAME_W-1:0]    s_tdata  = '0;
    // mode [0], first [1]
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // out_left [15:0], out_right [31:16]
    logic [FRAME_W-1:0]    m_tdata;
    // held [0]
    logic [0:0]            m_tuser;

    stereo_lerp_model model = new();
    bit                gaps_on     = 1'b1;
    int unsigned       items_sent  = 0;
    int unsigned       stall_cnt   = 0;
    int unsigned       cycles      = 0;

    linear_interp_stereo_resampler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always @(posedge aclk) begin
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= (stall_cnt == 1);
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_cnt <= $urandom_range(1, 9);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted output frame
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            model.check_frame(m_tdata, m_tuser[0]);
        end
    end

    task automatic send_item(bit emit, bit first, logic [SAMPLE_W-1:0] left,
                             logic [SAMPLE_W-1:0] right);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= {first, emit};
        do @(posedge aclk); while (!s_tready);
        model.take_item(emit, first, left, right);
        items_sent++;
    endtask

    // Emit with random content in the ignored fields
    task automatic send_emit();
        send_item(1'b1, 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Hold the input until every expected frame has come, then let the divider finish
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (model.frames_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [RATE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= {13'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model.set_rate(idx, value);
    endtask

    task automatic set_rates(logic [RATE_W-1:0] src, logic [RATE_W-1:0] dst);
        write_reg(REG_SRC_RATE, src);
        write_reg(REG_DST_RATE, dst);
    endtask

    initial begin
        int unsigned       n;
        int unsigned       m;
        int unsigned       goal;
        logic [RATE_W-1:0] src;
        logic [RATE_W-1:0] dst;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Emit with nothing loaded gives silence
        send_emit();
        // Load before any batch start: frame is appended, step stays zero
        send_item(1'b0, 1'b0, 16'h7FFF, 16'h8000);
        send_emit();
        send_emit();
        // Unity step over extreme samples, running into the held last frame
        send_item(1'b0, 1'b1, 16'h8000, 16'h7FFF);
        send_item(1'b0, 1'b0, 16'h7FFF, 16'h8000);
        send_item(1'b0, 1'b0, 16'h0000, 16'hFFFF);
        repeat (4) send_emit();

        // Upsample by three: fractions across full-scale swings in both directions
        quiesce();
        set_rates(RATE_W'(1), RATE_W'(3));
        send_item(1'b0, 1'b1, 16'h8000, 16'h7FFF);
        send_item(1'b0, 1'b0, 16'h7FFF, 16'h8000);
        send_item(1'b0, 1'b0, 16'h0001, 16'hFFFF);
        repeat (7) send_emit();

        // Zero source rate silences a loaded batch
        quiesce();
        set_rates(RATE_W'(0), RATE_W'(3));
        send_emit();

        // Zero destination rate at batch start gives a zero step and silence
        quiesce();
        set_rates(RATE_W'(RATE_TOP), RATE_W'(0));
        send_item(1'b0, 1'b1, 16'h1234, 16'hEDCB);
        send_emit();

        // Random batches under random rates
        goal = items_sent + 200;
        while (items_sent < goal) begin
            quiesce();
            case ($urandom_range(0, 9))
                0: begin
                    src = '0;
                    dst = RATE_W'($urandom_range(1, RATE_TOP));
                end
                1: begin
                    src = RATE_W'($urandom_range(1, RATE_TOP));
                    dst = '0;
                end
                2: begin
                    src = RATE_W'(RATE_TOP);
                    dst = RATE_W'(1);
                end
                3: begin
                    src = RATE_W'(1);
                    dst = RATE_W'(RATE_TOP);
                end
                default: begin
                    src = RATE_W'($urandom_range(1, RATE_TOP));
                    dst = RATE_W'($urandom_range(1, RATE_TOP));
                end
            endcase
            set_rates(src, dst);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4)) begin
                n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
                m = $urandom_range(1, 3 * n + 4);
                // Now and then extend the previous batch instead of starting one
                send_item(1'b0, ($urandom_range(0, 9) != 0), 16'($urandom), 16'($urandom));
                repeat (n - 1) send_item(1'b0, 1'b0, 16'($urandom), 16'($urandom));
                repeat (m) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_item(1'b0, 1'b0, 16'($urandom), 16'($urandom));
                    end
                    send_emit();
                end
                if ($urandom_range(0, 5) == 0) begin
                    quiesce();
                end
            end
        end

        // Fill the store past capacity and walk through its top entries
        quiesce();
        gaps_on = 1'b1;
        set_rates(RATE_W'($urandom_range(50000, 200000)), RATE_W'($urandom_range(900, 1100)));
        send_item(1'b0, 1'b1, 16'($urandom), 16'($urandom));
        repeat (MAX_FRAMES + 3) send_item(1'b0, 1'b0, 16'($urandom), 16'($urandom));
        repeat (14) send_emit();

        // Fast downsampling without idling, running into the held last frame
        quiesce();
        gaps_on = 1'b0;
        set_rates(RATE_W'(RATE_TOP), RATE_W'($urandom_range(20000, 200000)));
        send_item(1'b0, 1'b1, 16'($urandom), 16'($urandom));
        repeat (11) send_item(1'b0, 1'b0, 16'($urandom), 16'($urandom));
        repeat (24) send_emit();

        quiesce();
        if (model.errors == 0 && model.frames_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
